FILE: src/rflm_pkg.sv
package rflm_pkg;

    // Operation codes carried in the request beat.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_SEARCH  = 2'd2;

    // Status codes carried in the result beat.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_USED  = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] name_key;
        logic [4:0]  slot_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] slot_out;
        logic [5:0] used_count;
    } out_item_t;

endpackage

FILE: src/region_free_list_manager.sv
// Channel  Ports                        Beat contents
// -------  ---------------------------  --------------------------------------
// request  s_valid, s_ready, s_data     operation, name_key, slot_index
// result   m_valid, m_ready, m_data     status, slot_out, used_count
//
// One request is handled at a time; s_ready is high only while the sequencer is idle.
// Allocate steps through ALLOC and OUT, release through REL_CHK, REL_FIX and OUT
// (REL_CHK and OUT for a free slot), an unused code or an early error straight to OUT; a
// search visits up to NUM_REGIONS used-list links in SEARCH, one link per cycle through
// the registered read port of the link and name memories, then OUT. Reset is immediate:
// unissued slots are tracked by a fill mark. Stalled results sit in the output register.
module region_free_list_manager #(
    parameter int NUM_REGIONS = 32,
    parameter int NAME_BYTES  = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rflm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rflm_pkg::out_item_t m_data
);

    localparam int PTR_W  = $clog2(NUM_REGIONS + 1);
    localparam int ADDR_W = $clog2(NUM_REGIONS);
    localparam int NAME_W = 8 * NAME_BYTES;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_REGIONS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_REL_CHK,
        ST_REL_FIX,
        ST_SEARCH,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [PTR_W-1:0]  free_head_reg;
    logic [PTR_W-1:0]  used_head_reg;
    logic [PTR_W-1:0]  count_reg;
    logic [PTR_W-1:0]  fill_reg;     // slots at or above this were never allocated
    logic [PTR_W-1:0]  slot_reg;
    logic [PTR_W-1:0]  prev_reg;
    logic [PTR_W-1:0]  next_reg;
    logic [NAME_W-1:0] key_reg;
    logic [1:0]        res_status_reg;
    logic [PTR_W-1:0]  res_slot_reg;
    logic              m_valid_reg;
    rflm_pkg::out_item_t m_data_reg;

    // Memory ports. The next memory holds {in_use, next link}.
    logic [ADDR_W-1:0] rd_addr;
    logic              next_we;
    logic [ADDR_W-1:0] next_waddr;
    logic [PTR_W:0]    next_wdata;
    logic [PTR_W:0]    next_rdata;
    logic              prev_we;
    logic [ADDR_W-1:0] prev_waddr;
    logic [PTR_W-1:0]  prev_wdata;
    logic [PTR_W-1:0]  prev_rdata;
    logic              name_we;
    logic [NAME_W-1:0] name_rdata;

    logic [PTR_W-1:0] next_ptr;
    logic             next_used;
    logic             accept;
    logic             alloc_full;
    logic             idx_ok;
    logic             rel_ok;
    logic             out_free;
    logic [31:0]      slot_wide;
    logic [31:0]      count_wide;

    assign next_ptr   = next_rdata[PTR_W-1:0];
    assign next_used  = next_rdata[PTR_W];
    assign accept     = s_valid && s_ready;
    assign alloc_full = (count_reg >= NIL) || (free_head_reg >= NIL);
    assign idx_ok     = 32'(s_data.slot_index) < 32'(NUM_REGIONS);
    assign rel_ok     = (slot_reg < fill_reg) && next_used;
    assign out_free   = !m_valid_reg || m_ready;
    assign slot_wide  = 32'(res_slot_reg);
    assign count_wide = 32'(count_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // All three memories are always read at the same slot.
    always_comb begin
        rd_addr = '0;
        case (state_reg)
            ST_IDLE: begin
                case (s_data.operation)
                    rflm_pkg::OP_ALLOC:   rd_addr = free_head_reg[ADDR_W-1:0];
                    rflm_pkg::OP_RELEASE: rd_addr = ADDR_W'(s_data.slot_index);
                    rflm_pkg::OP_SEARCH:  rd_addr = used_head_reg[ADDR_W-1:0];
                    default:              rd_addr = '0;
                endcase
            end
            ST_SEARCH: rd_addr = next_ptr[ADDR_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = '0;
        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = '0;
        name_we    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.operation == rflm_pkg::OP_ALLOC && !alloc_full) begin
                    prev_we    = 1'b1;
                    prev_waddr = free_head_reg[ADDR_W-1:0];
                    prev_wdata = NIL;
                    name_we    = 1'b1;
                end
            end
            ST_ALLOC: begin
                next_we    = 1'b1;
                next_waddr = slot_reg[ADDR_W-1:0];
                next_wdata = {1'b1, used_head_reg};
                prev_we    = (used_head_reg != NIL);
                prev_waddr = used_head_reg[ADDR_W-1:0];
                prev_wdata = slot_reg;
            end
            ST_REL_CHK: begin
                if (rel_ok) begin
                    next_we    = 1'b1;
                    next_waddr = slot_reg[ADDR_W-1:0];
                    next_wdata = {1'b0, free_head_reg};
                    prev_we    = (next_ptr != NIL);
                    prev_waddr = next_ptr[ADDR_W-1:0];
                    prev_wdata = prev_rdata;
                end
            end
            ST_REL_FIX: begin
                next_we    = (prev_reg != NIL);
                next_waddr = prev_reg[ADDR_W-1:0];
                next_wdata = {1'b1, next_reg};
            end
            default: begin
                next_we = 1'b0;
            end
        endcase
    end

    rflm_ram #(.WIDTH(PTR_W + 1), .DEPTH(NUM_REGIONS)) u_next_ram (
        .clk   (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    rflm_ram #(.WIDTH(PTR_W), .DEPTH(NUM_REGIONS)) u_prev_ram (
        .clk   (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    rflm_ram #(.WIDTH(NAME_W), .DEPTH(NUM_REGIONS)) u_name_ram (
        .clk   (aclk),
        .we    (name_we),
        .waddr (free_head_reg[ADDR_W-1:0]),
        .wdata (s_data.name_key[NAME_W-1:0]),
        .raddr (rd_addr),
        .rdata (name_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            used_head_reg <= NIL;
            count_reg     <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // In ST_OUT the output register is reloaded instead.
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        key_reg <= s_data.name_key[NAME_W-1:0];
                        case (s_data.operation)
                            rflm_pkg::OP_ALLOC: begin
                                if (alloc_full) begin
                                    res_status_reg <= rflm_pkg::STS_FULL;
                                    res_slot_reg   <= '0;
                                    state_reg      <= ST_OUT;
                                end else begin
                                    slot_reg  <= free_head_reg;
                                    state_reg <= ST_ALLOC;
                                end
                            end
                            rflm_pkg::OP_RELEASE: begin
                                if (!idx_ok) begin
                                    res_status_reg <= rflm_pkg::STS_NOT_USED;
                                    res_slot_reg   <= '0;
                                    state_reg      <= ST_OUT;
                                end else begin
                                    slot_reg  <= PTR_W'(s_data.slot_index);
                                    state_reg <= ST_REL_CHK;
                                end
                            end
                            rflm_pkg::OP_SEARCH: begin
                                if (used_head_reg == NIL) begin
                                    res_status_reg <= rflm_pkg::STS_NOT_FOUND;
                                    res_slot_reg   <= '0;
                                    state_reg      <= ST_OUT;
                                end else begin
                                    slot_reg  <= used_head_reg;
                                    state_reg <= ST_SEARCH;
                                end
                            end
                            default: begin
                                res_status_reg <= rflm_pkg::STS_OK;
                                res_slot_reg   <= '0;
                                state_reg      <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_ALLOC: begin
                    // A slot at the fill mark links implicitly to the next one up.
                    if (slot_reg == fill_reg) begin
                        free_head_reg <= slot_reg + PTR_W'(1);
                        fill_reg      <= fill_reg + PTR_W'(1);
                    end else begin
                        free_head_reg <= next_ptr;
                    end
                    used_head_reg  <= slot_reg;
                    count_reg      <= count_reg + PTR_W'(1);
                    res_status_reg <= rflm_pkg::STS_OK;
                    res_slot_reg   <= slot_reg;
                    state_reg      <= ST_OUT;
                end
                ST_REL_CHK: begin
                    if (!rel_ok) begin
                        res_status_reg <= rflm_pkg::STS_NOT_USED;
                        res_slot_reg   <= '0;
                        state_reg      <= ST_OUT;
                    end else begin
                        prev_reg <= prev_rdata;
                        next_reg <= next_ptr;
                        if (used_head_reg == slot_reg) begin
                            used_head_reg <= next_ptr;
                        end
                        state_reg <= ST_REL_FIX;
                    end
                end
                ST_REL_FIX: begin
                    free_head_reg <= slot_reg;
                    if (count_reg != '0) begin
                        count_reg <= count_reg - PTR_W'(1);
                    end
                    res_status_reg <= rflm_pkg::STS_OK;
                    res_slot_reg   <= slot_reg;
                    state_reg      <= ST_OUT;
                end
                ST_SEARCH: begin
                    if (name_rdata == key_reg) begin
                        res_status_reg <= rflm_pkg::STS_OK;
                        res_slot_reg   <= slot_reg;
                        state_reg      <= ST_OUT;
                    end else if (next_ptr == NIL) begin
                        res_status_reg <= rflm_pkg::STS_NOT_FOUND;
                        res_slot_reg   <= '0;
                        state_reg      <= ST_OUT;
                    end else begin
                        slot_reg <= next_ptr;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.status     <= res_status_reg;
                        m_data_reg.slot_out   <= slot_wide[4:0];
                        m_data_reg.used_count <= count_wide[5:0];
                        state_reg             <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/rflm_ram.sv
module rflm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/rflm_checker.sv
module rflm_checker #(
    parameter int NUM_REGIONS = 32
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rflm_pkg::out_item_t m_data
);

    // A result beat that is not taken stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Only one request is in flight: the block closes its input right after a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // Every error result reports slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != rflm_pkg::STS_OK |-> m_data.slot_out == 5'd0)
        else $error("error result with nonzero slot");

    // A full status means every slot is in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == rflm_pkg::STS_FULL |->
            m_data.used_count == 6'(NUM_REGIONS))
        else $error("pool full reported with free slots");

    // The used count never exceeds the pool.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.used_count) <= 32'(NUM_REGIONS))
        else $error("used count beyond pool size");

endmodule

bind region_free_list_manager rflm_checker #(.NUM_REGIONS(NUM_REGIONS)) u_rflm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
